/* src/dct8c_pkg.sv */
// Shared types and constants for the eight-point column DCT pipeline.
// No dependencies; imported by the pipeline control and the top level.
package dct8c_pkg;

    // Number of register stages between the request port and the result port.
    localparam int STAGES = 6;

    // Q13 rotation constants (all below 2^14, so 15 bits signed hold them).
    localparam logic signed [14:0] K_C1 = 15'sd11362;
    localparam logic signed [14:0] K_C3 = 15'sd9632;
    localparam logic signed [14:0] K_C5 = 15'sd6436;
    localparam logic signed [14:0] K_C7 = 15'sd2260;
    localparam logic signed [14:0] K_C2 = 15'sd10703;
    localparam logic signed [14:0] K_C6 = 15'sd4433;

    // Q16 scale by the square root of one half, with its rounding offset.
    localparam logic signed [16:0] K_C0  = 17'sd46341;
    localparam logic signed [16:0] K_RND = 17'sd32767;

    // Per-stage load enables and valid flags handed from control to datapath.
    typedef struct packed {
        logic [STAGES-1:0] load;
        logic [STAGES-1:0] valid;
    } pipe_ctl_t;

endpackage

/* src/dct8c_ctrl.sv */
// Valid and back-pressure control for the column DCT pipeline.
// Depends on dct8c_pkg for the stage count and the control struct.
module dct8c_ctrl
    import dct8c_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  logic      out_ready,
    output pipe_ctl_t ctl
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] load;
    logic [STAGES:0]   ready_chain;
    logic [STAGES-1:0] feed;
    logic              in_acc;
    logic              out_acc;

    // A stage may load when it is empty or when its contents move on.
    always_comb begin
        ready_chain[STAGES] = out_ready;
        for (int i = STAGES - 1; i >= 0; i--) begin
            load[i]        = !valid_reg[i] || ready_chain[i+1];
            ready_chain[i] = load[i];
        end
    end

    assign feed = {valid_reg[STAGES-2:0], in_valid};

    always_comb begin
        valid_next = valid_reg;
        for (int i = 0; i < STAGES; i++) begin
            if (load[i]) begin
                valid_next[i] = feed[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.load  = load;
    assign ctl.valid = valid_reg;

    assign in_acc  = in_valid && load[0];
    assign out_acc = valid_reg[STAGES-1] && out_ready;

    // Every accepted request is held in exactly one stage until it leaves.
    a_count_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> int'($countones(valid_reg)) ==
                 int'($past($countones(valid_reg))) + int'($past(in_acc))
                 - int'($past(out_acc)))
        else $error("pipeline occupancy does not match requests in and out");

    // Requests are refused only when every stage is occupied.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !load[0] |-> &valid_reg)
        else $error("input refused while a stage is empty");

    // An accepted request lands in the first stage.
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> valid_reg[0])
        else $error("accepted request lost at entry");

endmodule

/* src/dct8_column_fixed_point.sv */
// Eight-point forward DCT column pass, top level with the six-stage datapath.
// Depends on dct8c_pkg and instantiates dct8c_ctrl.
//
// One request carries a column of eight signed 16-bit samples on
// s_sample_0..s_sample_7 and is taken when s_valid and s_ready are both high.
// Each request gives exactly one result of eight coefficients on
// m_coef_0..m_coef_7, handed over when m_valid and m_ready are both high.
// Coefficients 0 and 4 are 19-bit plain sums; the others are 18-bit product
// sums shifted right arithmetically by 13.
// A request passes through six register stages (butterfly, second butterfly,
// multiplies, rounding and odd butterfly, odd multiplies, final sums) before
// m_valid rises. A request may enter every cycle while m_ready is high, so a
// sustained rate of one column per cycle is reached.
// A synchronous active-low reset on aresetn empties the pipeline; results in
// flight are dropped. When the receiver holds m_ready low the stages fill up
// behind the waiting result, bubbles close, and s_ready falls only once every
// stage is occupied. Nothing is lost or repeated across a stall.
module dct8_column_fixed_point
    import dct8c_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_sample_0,
    input  logic signed [15:0]  s_sample_1,
    input  logic signed [15:0]  s_sample_2,
    input  logic signed [15:0]  s_sample_3,
    input  logic signed [15:0]  s_sample_4,
    input  logic signed [15:0]  s_sample_5,
    input  logic signed [15:0]  s_sample_6,
    input  logic signed [15:0]  s_sample_7,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [18:0]  m_coef_0,
    output logic signed [17:0]  m_coef_1,
    output logic signed [17:0]  m_coef_2,
    output logic signed [17:0]  m_coef_3,
    output logic signed [18:0]  m_coef_4,
    output logic signed [17:0]  m_coef_5,
    output logic signed [17:0]  m_coef_6,
    output logic signed [17:0]  m_coef_7
);

    pipe_ctl_t ctl;

    dct8c_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .out_ready (m_ready),
        .ctl       (ctl)
    );

    assign s_ready = ctl.load[0];
    assign m_valid = ctl.valid[STAGES-1];

    // Stage 1: first butterfly. Sums are exact, differences wrap to 16 bits.
    logic signed [16:0] g0_reg, g1_reg, h0_reg, h1_reg;
    logic signed [15:0] h2_reg, h3_reg, g2_reg, g3_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            g0_reg <= 17'(s_sample_0) + 17'(s_sample_7);
            g1_reg <= 17'(s_sample_1) + 17'(s_sample_6);
            h1_reg <= 17'(s_sample_2) + 17'(s_sample_5);
            h0_reg <= 17'(s_sample_3) + 17'(s_sample_4);
            h2_reg <= s_sample_0 - s_sample_7;
            h3_reg <= s_sample_1 - s_sample_6;
            g3_reg <= s_sample_2 - s_sample_5;
            g2_reg <= s_sample_3 - s_sample_4;
        end
    end

    // Stage 2: even butterfly and the odd pair ahead of the half scaling.
    logic signed [17:0] p0_reg, p1_reg;
    logic signed [15:0] r0_reg, r1_reg, q1_s2_reg, s1_s2_reg, sa_reg, qa_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load[1]) begin
            p0_reg    <= 18'(g0_reg) + 18'(h0_reg);
            p1_reg    <= 18'(g1_reg) + 18'(h1_reg);
            r0_reg    <= 16'(g0_reg - h0_reg);
            r1_reg    <= 16'(g1_reg - h1_reg);
            q1_s2_reg <= g2_reg;
            s1_s2_reg <= h2_reg;
            sa_reg    <= h3_reg + g3_reg;
            qa_reg    <= h3_reg - g3_reg;
        end
    end

    // Stage 3: all products of this stage, plus the unscaled DC and
    // frequency-4 sums.
    logic signed [18:0] e0_s3_reg, e4_s3_reg;
    logic signed [30:0] m6r1_reg, m2r0_reg, m6r0_reg, m2r1_reg;
    logic signed [32:0] psa_reg, pqa_reg;
    logic signed [15:0] q1_s3_reg, s1_s3_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load[2]) begin
            e0_s3_reg <= 19'(p0_reg) + 19'(p1_reg);
            e4_s3_reg <= 19'(p0_reg) - 19'(p1_reg);
            m6r1_reg  <= 31'(K_C6) * 31'(r1_reg);
            m2r0_reg  <= 31'(K_C2) * 31'(r0_reg);
            m6r0_reg  <= 31'(K_C6) * 31'(r0_reg);
            m2r1_reg  <= 31'(K_C2) * 31'(r1_reg);
            psa_reg   <= 33'(K_C0) * 33'(sa_reg);
            pqa_reg   <= 33'(K_C0) * 33'(qa_reg);
            q1_s3_reg <= q1_s2_reg;
            s1_s3_reg <= s1_s2_reg;
        end
    end

    // Stage 4: round the half-scaled odd terms, finish coefficients 2 and 6,
    // and form the odd butterfly in 16-bit wrapping arithmetic.
    logic signed [32:0] s0_round;
    logic signed [32:0] q0_round;
    logic signed [15:0] s0_val, q0_val;
    logic signed [31:0] e2_sum, e6_sum;

    always_comb begin
        s0_round = psa_reg + 33'(K_RND);
        q0_round = pqa_reg + 33'(K_RND);
        s0_val   = s0_round[31:16];
        q0_val   = q0_round[31:16];
        e2_sum   = 32'(m6r1_reg) + 32'(m2r0_reg);
        e6_sum   = 32'(m6r0_reg) - 32'(m2r1_reg);
    end

    logic signed [18:0] e0_s4_reg, e4_s4_reg;
    logic signed [17:0] e2_s4_reg, e6_s4_reg;
    logic signed [15:0] oq1_reg, oq0_reg, os1_reg, os0_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load[3]) begin
            e0_s4_reg <= e0_s3_reg;
            e4_s4_reg <= e4_s3_reg;
            e2_s4_reg <= e2_sum[30:13];
            e6_s4_reg <= e6_sum[30:13];
            oq1_reg   <= q1_s3_reg + q0_val;
            oq0_reg   <= q1_s3_reg - q0_val;
            os1_reg   <= s1_s3_reg + s0_val;
            os0_reg   <= s1_s3_reg - s0_val;
        end
    end

    // Stage 5: odd rotation products.
    logic signed [18:0] e0_s5_reg, e4_s5_reg;
    logic signed [17:0] e2_s5_reg, e6_s5_reg;
    logic signed [30:0] m7q1_reg, m1s1_reg, m7s1_reg, m1q1_reg;
    logic signed [30:0] m3q0_reg, m5s0_reg, m3s0_reg, m5q0_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load[4]) begin
            e0_s5_reg <= e0_s4_reg;
            e4_s5_reg <= e4_s4_reg;
            e2_s5_reg <= e2_s4_reg;
            e6_s5_reg <= e6_s4_reg;
            m7q1_reg  <= 31'(K_C7) * 31'(oq1_reg);
            m1s1_reg  <= 31'(K_C1) * 31'(os1_reg);
            m7s1_reg  <= 31'(K_C7) * 31'(os1_reg);
            m1q1_reg  <= 31'(K_C1) * 31'(oq1_reg);
            m3q0_reg  <= 31'(K_C3) * 31'(oq0_reg);
            m5s0_reg  <= 31'(K_C5) * 31'(os0_reg);
            m3s0_reg  <= 31'(K_C3) * 31'(os0_reg);
            m5q0_reg  <= 31'(K_C5) * 31'(oq0_reg);
        end
    end

    // Stage 6: odd sums, shifted right by 13, and the even coefficients into the result register.
    logic signed [31:0] o1_sum, o7_sum, o5_sum, o3_sum;

    always_comb begin
        o1_sum = 32'(m7q1_reg) + 32'(m1s1_reg);
        o7_sum = 32'(m7s1_reg) - 32'(m1q1_reg);
        o5_sum = 32'(m3q0_reg) + 32'(m5s0_reg);
        o3_sum = 32'(m3s0_reg) - 32'(m5q0_reg);
    end

    logic signed [18:0] coef0_reg, coef4_reg;
    logic signed [17:0] coef1_reg, coef2_reg, coef3_reg;
    logic signed [17:0] coef5_reg, coef6_reg, coef7_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load[5]) begin
            coef0_reg <= e0_s5_reg;
            coef4_reg <= e4_s5_reg;
            coef2_reg <= e2_s5_reg;
            coef6_reg <= e6_s5_reg;
            coef1_reg <= o1_sum[30:13];
            coef7_reg <= o7_sum[30:13];
            coef5_reg <= o5_sum[30:13];
            coef3_reg <= o3_sum[30:13];
        end
    end

    assign m_coef_0 = coef0_reg;
    assign m_coef_1 = coef1_reg;
    assign m_coef_2 = coef2_reg;
    assign m_coef_3 = coef3_reg;
    assign m_coef_4 = coef4_reg;
    assign m_coef_5 = coef5_reg;
    assign m_coef_6 = coef6_reg;
    assign m_coef_7 = coef7_reg;

endmodule

/* verif/tb_dct8_column_fixed_point.sv */
`timescale 1ns / 100ps
// Testbench for dct8_column_fixed_point: directed and random columns, checked against
// a fixed-point column DCT predictor. Depends on the top level in src only.
module tb_dct8_column_fixed_point;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;

    localparam logic signed [15:0] S_MAX = 16'sh7FFF;
    localparam logic signed [15:0] S_MIN = 16'sh8000;

    // Fixed-point constants of the column transform.
    localparam longint ROT_C1     = 11362;
    localparam longint ROT_C3     = 9632;
    localparam longint ROT_C5     = 6436;
    localparam longint ROT_C7     = 2260;
    localparam longint ROT_C2     = 10703;
    localparam longint ROT_C6     = 4433;
    localparam longint HALF_ROOT  = 46341;
    localparam longint HALF_ROUND = 32767;
    localparam int     HALF_SHIFT = 16;
    localparam int     ROT_SHIFT  = 13;

    typedef logic signed [15:0] sample_vec_t [8];

    typedef struct packed {
        logic signed [18:0] coef_0;
        logic signed [17:0] coef_1;
        logic signed [17:0] coef_2;
        logic signed [17:0] coef_3;
        logic signed [18:0] coef_4;
        logic signed [17:0] coef_5;
        logic signed [17:0] coef_6;
        logic signed [17:0] coef_7;
    } col_coefs_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_sample_0 = '0;
    logic signed [15:0] s_sample_1 = '0;
    logic signed [15:0] s_sample_2 = '0;
    logic signed [15:0] s_sample_3 = '0;
    logic signed [15:0] s_sample_4 = '0;
    logic signed [15:0] s_sample_5 = '0;
    logic signed [15:0] s_sample_6 = '0;
    logic signed [15:0] s_sample_7 = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [18:0] m_coef_0;
    logic signed [17:0] m_coef_1;
    logic signed [17:0] m_coef_2;
    logic signed [17:0] m_coef_3;
    logic signed [18:0] m_coef_4;
    logic signed [17:0] m_coef_5;
    logic signed [17:0] m_coef_6;
    logic signed [17:0] m_coef_7;

    col_coefs_t pending_coefs[$];
    int         mismatches = 0;
    int         cycle_count = 0;
    int         rx_stall = 0;
    bit         tx_idle_en = 1'b0;
    bit         rx_idle_en = 1'b0;

    dct8_column_fixed_point uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample_0 (s_sample_0),
        .s_sample_1 (s_sample_1),
        .s_sample_2 (s_sample_2),
        .s_sample_3 (s_sample_3),
        .s_sample_4 (s_sample_4),
        .s_sample_5 (s_sample_5),
        .s_sample_6 (s_sample_6),
        .s_sample_7 (s_sample_7),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_coef_0   (m_coef_0),
        .m_coef_1   (m_coef_1),
        .m_coef_2   (m_coef_2),
        .m_coef_3   (m_coef_3),
        .m_coef_4   (m_coef_4),
        .m_coef_5   (m_coef_5),
        .m_coef_6   (m_coef_6),
        .m_coef_7   (m_coef_7)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Intermediates declared short in the original arithmetic wrap to 16 bits.
    function automatic longint wrap16(input longint x);
        logic signed [15:0] t;
        t = x[15:0];
        return t;
    endfunction

    function automatic longint scale_half_root(input longint x);
        return wrap16((x * HALF_ROOT + HALF_ROUND) >>> HALF_SHIFT);
    endfunction

    function automatic col_coefs_t dct_column(input sample_vec_t s);
        longint g0, g1, g2, g3, h0, h1, h2, h3;
        longint p0, p1, r0, r1, sa, qa, s0, q0;
        longint e2, e6, oq0, oq1, os0, os1, o1, o3, o5, o7;
        col_coefs_t c;
        g0 = longint'(s[0]) + s[7];  h2 = wrap16(longint'(s[0]) - s[7]);
        g1 = longint'(s[1]) + s[6];  h3 = wrap16(longint'(s[1]) - s[6]);
        h1 = longint'(s[2]) + s[5];  g3 = wrap16(longint'(s[2]) - s[5]);
        h0 = longint'(s[3]) + s[4];  g2 = wrap16(longint'(s[3]) - s[4]);
        p0 = g0 + h0;  r0 = wrap16(g0 - h0);
        p1 = g1 + h1;  r1 = wrap16(g1 - h1);
        sa = wrap16(h3 + g3);
        qa = wrap16(h3 - g3);
        s0 = scale_half_root(sa);
        q0 = scale_half_root(qa);
        e2 = ROT_C6 * r1 + ROT_C2 * r0;
        e6 = ROT_C6 * r0 - ROT_C2 * r1;
        oq1 = wrap16(g2 + q0);  oq0 = wrap16(g2 - q0);
        os1 = wrap16(h2 + s0);  os0 = wrap16(h2 - s0);
        o1 = ROT_C7 * oq1 + ROT_C1 * os1;
        o7 = ROT_C7 * os1 - ROT_C1 * oq1;
        o5 = ROT_C3 * oq0 + ROT_C5 * os0;
        o3 = ROT_C3 * os0 - ROT_C5 * oq0;
        c.coef_0 = 19'(p0 + p1);
        c.coef_1 = 18'(o1 >>> ROT_SHIFT);
        c.coef_2 = 18'(e2 >>> ROT_SHIFT);
        c.coef_3 = 18'(o3 >>> ROT_SHIFT);
        c.coef_4 = 19'(p0 - p1);
        c.coef_5 = 18'(o5 >>> ROT_SHIFT);
        c.coef_6 = 18'(e6 >>> ROT_SHIFT);
        c.coef_7 = 18'(o7 >>> ROT_SHIFT);
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [18:0] got,
                                   input logic [18:0] want);
        $display("ERROR at cycle %0d: %s got 0x%05h expected 0x%05h",
                 cycle_count, what, got, want);
        mismatches++;
    endtask

    task automatic check_coef(input string name, input logic [18:0] got,
                              input logic [18:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    // Sends one column and holds it until the request is taken.
    task automatic send_column(input sample_vec_t col);
        s_valid    <= 1'b1;
        s_sample_0 <= col[0];
        s_sample_1 <= col[1];
        s_sample_2 <= col[2];
        s_sample_3 <= col[3];
        s_sample_4 <= col[4];
        s_sample_5 <= col[5];
        s_sample_6 <= col[6];
        s_sample_7 <= col[7];
        do @(posedge aclk); while (!s_ready);
        pending_coefs.push_back(dct_column(col));
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (pending_coefs.size() != 0)
            @(posedge aclk);
    endtask

    function automatic sample_vec_t full_range_column();
        sample_vec_t col;
        foreach (col[i])
            col[i] = 16'($urandom);
        return col;
    endfunction

    function automatic sample_vec_t small_column();
        sample_vec_t col;
        foreach (col[i])
            col[i] = 16'($urandom_range(0, 63)) - 16'sd32;
        return col;
    endfunction

    function automatic sample_vec_t extreme_column();
        sample_vec_t col;
        foreach (col[i]) begin
            case ($urandom_range(0, 5))
                0: col[i] = S_MIN;
                1: col[i] = S_MAX;
                2: col[i] = 16'sd0;
                3: col[i] = -16'sd1;
                4: col[i] = 16'sd1;
                default: col[i] = 16'($urandom);
            endcase
        end
        return col;
    endfunction

    task automatic test_directed();
        sample_vec_t col;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_column('{default: 16'sd0});
        send_column('{default: S_MAX});
        send_column('{default: S_MIN});
        send_column('{S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN});
        send_column('{S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX});
        // Opposite extremes across three of the butterfly pairs make the short differences wrap.
        send_column('{S_MAX, S_MAX, S_MIN, 16'sd0, 16'sd0, S_MAX, S_MIN, S_MIN});
        // Small negative values exercise the rounding toward minus infinity.
        send_column('{-16'sd1, -16'sd2, -16'sd3, -16'sd4, -16'sd5, -16'sd6, -16'sd7, -16'sd8});
        send_column('{default: -16'sd1});
        send_column('{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd1});
        for (int k = 0; k < 8; k++) begin
            col = '{default: 16'sd0};
            col[k] = S_MAX;
            send_column(col);
            col[k] = S_MIN;
            send_column(col);
        end
    endtask

    task automatic test_random_full(input int count);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (count) send_column(full_range_column());
    endtask

    task automatic test_back_to_back_small(input int count);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        repeat (count) send_column(small_column());
    endtask

    task automatic test_random_extremes(input int count);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b0;
        repeat (count) send_column(extreme_column());
    endtask

    task automatic test_steady_stream(input int count);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (count) begin
            if ($urandom_range(0, 1) == 0)
                send_column(full_range_column());
            else
                send_column(extreme_column());
        end
    endtask

    // Receiver back-pressure: random bursts with m_ready low.
    always @(posedge aclk) begin
        if (rx_stall > 0) begin
            m_ready  <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
            m_ready  <= 1'b0;
            rx_stall <= $urandom_range(0, 11);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        col_coefs_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_coefs.size() == 0) begin
                report_mismatch("result with no request pending", m_coef_0, '0);
            end else begin
                want = pending_coefs.pop_front();
                check_coef("coef_0", m_coef_0, want.coef_0);
                check_coef("coef_1", 19'(m_coef_1), 19'(want.coef_1));
                check_coef("coef_2", 19'(m_coef_2), 19'(want.coef_2));
                check_coef("coef_3", 19'(m_coef_3), 19'(want.coef_3));
                check_coef("coef_4", m_coef_4, want.coef_4);
                check_coef("coef_5", 19'(m_coef_5), 19'(want.coef_5));
                check_coef("coef_6", 19'(m_coef_6), 19'(want.coef_6));
                check_coef("coef_7", 19'(m_coef_7), 19'(want.coef_7));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("dct8_column_fixed_point test failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        wait_all_results();
        test_random_full(400);
        // The sender holds off here until every result is back.
        wait_all_results();
        test_back_to_back_small(200);
        wait_all_results();
        test_random_extremes(200);
        wait_all_results();
        test_steady_stream(150);
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("dct8_column_fixed_point test passed");
        else
            $display("dct8_column_fixed_point test failed");
        $finish;
    end

endmodule
